FILE: sv/rmt_pkg.sv
package rmt_pkg;

  // Width of the input and result fields on the ports
  localparam int unsigned FIELD_W = 34;

  localparam int unsigned VALUE_BITS_DEF = 34;
  localparam longint unsigned DIVISOR_LIMIT_DEF = 64'd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G_CHK,
    ST_G_WAIT,
    ST_Q_WAIT,
    ST_T_CHK,
    ST_T_WAIT,
    ST_MUL,
    ST_FINAL,
    ST_OUT
  } state_t;

endpackage

FILE: sv/rmt_divider.sv
module rmt_divider #(
  parameter int unsigned W = rmt_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dsr;
  logic [W+1:0]     diff;

  // restoring step: one quotient bit a cycle, MSB first
  assign diff = {1'b0, remainder, quotient[W-1]} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      if (!diff[W+1]) begin
        remainder <= diff[W-1:0];
      end else begin
        remainder <= {remainder[W-2:0], quotient[W-1]};
      end
      quotient <= {quotient[W-2:0], ~diff[W+1]};
    end
  end

endmodule

FILE: sv/reduced_modulus_totient_core.sv
// Returns phi(m / gcd(a, m)) for each transferred pair (a, m), one result per
// pair; a zero modulus, or a zero a, gives 1. Input bits above VALUE_BITS are
// ignored. Work goes through one iterative divider and a shift-add multiplier.
// A pair takes roughly (Euclid steps + 1) divisions, then one division per
// trial candidate (2, 3, 5, 7, ... up to min(DIVISOR_LIMIT, sqrt(quotient)))
// plus one division and one product per prime factor found, then at most one
// more product. One pair is in work at a time; a new pair is taken only once
// the previous result sits in the output register, which holds it until the
// far side transfers it. Cofactors left above DIVISOR_LIMIT are taken as
// prime, which is exact when DIVISOR_LIMIT squared is at least
// 2^VALUE_BITS - 1.
module reduced_modulus_totient_core #(
  parameter int unsigned     VALUE_BITS    = rmt_pkg::VALUE_BITS_DEF,
  parameter longint unsigned DIVISOR_LIMIT = rmt_pkg::DIVISOR_LIMIT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rmt_pkg::FIELD_W-1:0] a_value,
  input  logic [rmt_pkg::FIELD_W-1:0] modulus,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rmt_pkg::FIELD_W-1:0] coprime_count
);

  localparam int unsigned W     = VALUE_BITS;
  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned CMP_W = (W > 33) ? W : 33;

  rmt_pkg::state_t state, state_next;

  logic [W-1:0]     xr, yr, m_r, n, p, total, mul_x, acc;
  logic [CNT_W-1:0] mul_cnt;
  logic             first, mul_final;

  logic             div_start, div_done;
  logic [W-1:0]     div_a, div_b, div_quo, div_rem;
  logic [W-1:0]     mul_sum, p_adv;
  logic             mul_last, p_in_lim, in_xfer, out_load;

  rmt_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign mul_sum  = {acc[W-2:0], 1'b0} + (mul_x[mul_cnt] ? total : '0);
  assign mul_last = (mul_cnt == '0);
  assign p_in_lim = CMP_W'(p) <= CMP_W'(DIVISOR_LIMIT);
  assign p_adv    = (p == W'(2)) ? W'(3) : p + W'(2);
  assign in_xfer  = in_valid && !in_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rmt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (W'(modulus) == '0) ? rmt_pkg::ST_FINAL : rmt_pkg::ST_G_CHK;
        end
      end
      rmt_pkg::ST_G_CHK: begin
        state_next = (xr == '0) ? rmt_pkg::ST_Q_WAIT : rmt_pkg::ST_G_WAIT;
      end
      rmt_pkg::ST_G_WAIT: begin
        if (div_done) state_next = rmt_pkg::ST_G_CHK;
      end
      rmt_pkg::ST_Q_WAIT: begin
        if (div_done) state_next = rmt_pkg::ST_T_CHK;
      end
      rmt_pkg::ST_T_CHK: begin
        state_next = p_in_lim ? rmt_pkg::ST_T_WAIT : rmt_pkg::ST_FINAL;
      end
      rmt_pkg::ST_T_WAIT: begin
        if (div_done) begin
          if (first && div_quo < p) state_next = rmt_pkg::ST_FINAL;
          else if (div_rem == '0)   state_next = rmt_pkg::ST_MUL;
          else                      state_next = rmt_pkg::ST_T_CHK;
        end
      end
      rmt_pkg::ST_MUL: begin
        if (mul_last) state_next = mul_final ? rmt_pkg::ST_OUT : rmt_pkg::ST_T_WAIT;
      end
      rmt_pkg::ST_FINAL: begin
        state_next = (n > W'(1)) ? rmt_pkg::ST_MUL : rmt_pkg::ST_OUT;
      end
      rmt_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = rmt_pkg::ST_IDLE;
      end
      default: state_next = rmt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    div_a     = n;
    div_b     = p;
    out_load  = 1'b0;
    case (state)
      rmt_pkg::ST_IDLE: in_stall = 1'b0;
      rmt_pkg::ST_G_CHK: begin
        div_start = 1'b1;
        if (xr == '0) begin
          div_a = m_r;
          div_b = yr;
        end else begin
          div_a = yr;
          div_b = xr;
        end
      end
      rmt_pkg::ST_T_CHK: div_start = p_in_lim;
      rmt_pkg::ST_MUL:   div_start = mul_last && !mul_final;
      rmt_pkg::ST_OUT:   out_load  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rmt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)                    out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) coprime_count <= rmt_pkg::FIELD_W'(total);
    case (state)
      rmt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          xr        <= W'(a_value);
          yr        <= W'(modulus);
          m_r       <= W'(modulus);
          n         <= '0;
          total     <= W'(1);
          mul_final <= 1'b0;
        end
      end
      rmt_pkg::ST_G_WAIT: begin
        if (div_done) begin
          yr <= xr;
          xr <= div_rem;
        end
      end
      rmt_pkg::ST_Q_WAIT: begin
        if (div_done) begin
          n <= div_quo;
          p <= W'(2);
        end
      end
      rmt_pkg::ST_T_CHK: first <= 1'b1;
      rmt_pkg::ST_T_WAIT: begin
        if (div_done && !(first && div_quo < p)) begin
          if (div_rem == '0) begin
            n       <= div_quo;
            mul_x   <= first ? p - W'(1) : p;
            acc     <= '0;
            mul_cnt <= CNT_W'(W - 1);
          end else begin
            p <= p_adv;
          end
        end
      end
      rmt_pkg::ST_MUL: begin
        acc     <= mul_sum;
        mul_cnt <= mul_cnt - CNT_W'(1);
        if (mul_last) begin
          total <= mul_sum;
          first <= 1'b0;
        end
      end
      rmt_pkg::ST_FINAL: begin
        // leftover cofactor above 1 counts as prime
        mul_x     <= n - W'(1);
        acc       <= '0;
        mul_cnt   <= CNT_W'(W - 1);
        mul_final <= 1'b1;
      end
      default: ;
    endcase
  end

  a_gcd_divides: assert property (@(posedge clk) disable iff (rst)
    (state == rmt_pkg::ST_Q_WAIT && div_done) |-> div_rem == '0)
    else $error("gcd does not divide the modulus");

  a_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == rmt_pkg::ST_G_WAIT || state == rmt_pkg::ST_Q_WAIT ||
                  state == rmt_pkg::ST_T_WAIT))
    else $error("divider finished outside a wait state");

  a_candidate_ok: assert property (@(posedge clk) disable iff (rst)
    (state == rmt_pkg::ST_T_CHK) |-> (p == W'(2) || (p[0] && p > W'(2))))
    else $error("bad trial candidate");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == rmt_pkg::ST_OUT)
    else $error("result raised outside output state");

endmodule
